/* rtl/core/ludp_pkg.sv */
// ----------------------------------------------------------------------------
// ludp_pkg
// Constants, codes and record type for the lidar UDP packet parser.
// ----------------------------------------------------------------------------
package ludp_pkg;

  localparam int FIRING_BLOCKS    = 12;
  localparam int LASERS_PER_BLOCK = 32;
  localparam int ETH_HEADER_BYTES = 14;

  localparam int          PROTO_UDP        = 17;
  localparam int          UDP_HEADER_BYTES = 8;
  localparam int          MIN_IP_HEADER    = 20;
  localparam logic [15:0] LIDAR_PORT_RESET = 16'd2368;

  localparam int POS_W  = 11;
  localparam int CALC_W = POS_W + 1;
  localparam int BC_W   = $clog2(FIRING_BLOCKS + 1);
  localparam int LC_W   = $clog2(LASERS_PER_BLOCK + 1);

  localparam int OUT_DATA_W = 72;

  typedef enum logic {
    KIND_LASER  = 1'b0,
    KIND_STATUS = 1'b1
  } record_kind_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_SHORT_IHL = 3'd1,
    ST_NOT_UDP   = 3'd2,
    ST_BAD_PORT  = 3'd3,
    ST_EMPTY     = 3'd4
  } frame_status_t;

  typedef struct packed {
    record_kind_t  record_kind;
    logic [3:0]    block_index;
    logic [15:0]   block_identifier;
    logic [15:0]   azimuth;
    logic [4:0]    laser_index;
    logic [15:0]   distance;
    logic [7:0]    intensity;
    frame_status_t frame_status;
    logic          last;
  } record_t;

endpackage

/* rtl/core/lidar_udp_packet_parser.sv */
// ----------------------------------------------------------------------------
// lidar_udp_packet_parser
// Parses Ethernet/IPv4/UDP lidar frames byte by byte into return records.
// ----------------------------------------------------------------------------
// Input channel in_*: one frame byte per item, in_tlast on the final byte.
// Output channel out_*: one record per item; out_tuser is the record kind
// (laser return or frame status), out_tlast marks the status record that
// closes a frame. A laser record follows the intensity byte of each return
// in an accepted frame; every frame ends with one status record.
// cfg_wr_en/cfg_wr_data set the UDP destination port (reset value 2368).
// Each accepted byte is parsed in the cycle it is taken; its records are
// written into a four-entry output queue register that drives out_*.
// One byte per cycle while in_tready is high; at most two records a byte.
// in_tready drops only when the queue has fewer than two free entries, i.e.
// while the receiver stalls out_tready; items are held, never dropped.
// Reset (rst_n low, synchronous) clears all frame state and empties the
// queue; the port register returns to 2368.
// ----------------------------------------------------------------------------
module lidar_udp_packet_parser
  import ludp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [15:0]           cfg_wr_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] frame_byte
  input  logic                  in_tlast,   // frame_last
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // block_index, block_identifier,
                                            // azimuth, laser_index, distance,
                                            // intensity, frame_status, zero pad
  output logic                  out_tuser,  // record_kind
  output logic                  out_tlast   // last
);

  localparam logic [CALC_W-1:0] E_POS = CALC_W'(ETH_HEADER_BYTES);
  localparam logic [POS_W-1:0]  POS_MAX = {POS_W{1'b1}};

  logic [15:0]       lidar_port_r;
  logic [POS_W-1:0]  byte_position_r, byte_position_nxt;
  logic [5:0]        ip_header_bytes_r, ip_header_bytes_nxt;
  logic [15:0]       ip_total_length_r, ip_total_length_nxt;
  frame_status_t     reject_code_r, reject_code_nxt;
  logic [7:0]        port_high_byte_r, port_high_byte_nxt;
  logic [7:0]        low_byte_hold_r, low_byte_hold_nxt;
  logic [15:0]       current_identifier_r, current_identifier_nxt;
  logic [15:0]       current_azimuth_r, current_azimuth_nxt;
  logic [15:0]       current_distance_r, current_distance_nxt;
  logic [BC_W-1:0]   block_counter_r, block_counter_nxt;
  logic [LC_W-1:0]   laser_counter_r, laser_counter_nxt;
  logic [1:0]        byte_phase_r, byte_phase_nxt;
  logic              in_block_header_r, in_block_header_nxt;
  logic              walk_done_r, walk_done_nxt;

  record_t           queue_r [4];
  logic [1:0]        wr_ptr_r, rd_ptr_r;
  logic [2:0]        count_r;

  logic              in_fire, out_fire;
  logic [7:0]        b;
  logic [CALC_W-1:0] pos, ihl, payload_start;
  logic              emit_laser;
  record_t           laser_rec, status_rec;
  logic [15:0]       port_word;
  frame_status_t     status_code;

  assign in_tready = (count_r <= 3'd2);
  assign in_fire   = in_tvalid && in_tready;

  assign b             = in_tdata;
  assign pos           = CALC_W'(byte_position_r);
  assign ihl           = CALC_W'(ip_header_bytes_r);
  assign payload_start = E_POS + ihl + CALC_W'(UDP_HEADER_BYTES);
  assign port_word     = {port_high_byte_r, b};

  always_comb begin
    byte_position_nxt      = byte_position_r;
    ip_header_bytes_nxt    = ip_header_bytes_r;
    ip_total_length_nxt    = ip_total_length_r;
    reject_code_nxt        = reject_code_r;
    port_high_byte_nxt     = port_high_byte_r;
    low_byte_hold_nxt      = low_byte_hold_r;
    current_identifier_nxt = current_identifier_r;
    current_azimuth_nxt    = current_azimuth_r;
    current_distance_nxt   = current_distance_r;
    block_counter_nxt      = block_counter_r;
    laser_counter_nxt      = laser_counter_r;
    byte_phase_nxt         = byte_phase_r;
    in_block_header_nxt    = in_block_header_r;
    walk_done_nxt          = walk_done_r;
    emit_laser             = 1'b0;

    if (pos == E_POS) begin
      ip_header_bytes_nxt = {b[3:0], 2'b00};
      if ((CALC_W'({b[3:0], 2'b00}) < CALC_W'(MIN_IP_HEADER)) &&
          (reject_code_r == ST_ACCEPTED)) begin
        reject_code_nxt = ST_SHORT_IHL;
      end
    end else if (pos == E_POS + CALC_W'(2)) begin
      ip_total_length_nxt = {b, 8'h00};
    end else if (pos == E_POS + CALC_W'(3)) begin
      ip_total_length_nxt = {ip_total_length_r[15:8], b};
    end else if (pos == E_POS + CALC_W'(9)) begin
      if ((reject_code_r == ST_ACCEPTED) && (b != 8'(PROTO_UDP))) begin
        reject_code_nxt = ST_NOT_UDP;
      end
    end else if ((reject_code_r == ST_ACCEPTED) && (pos == E_POS + ihl + CALC_W'(2))) begin
      port_high_byte_nxt = b;
    end else if ((reject_code_r == ST_ACCEPTED) && (pos == E_POS + ihl + CALC_W'(3))) begin
      if (port_word != lidar_port_r) begin
        reject_code_nxt = ST_BAD_PORT;
      end else if (ip_total_length_r <= 16'(ip_header_bytes_r) + 16'(UDP_HEADER_BYTES)) begin
        reject_code_nxt = ST_EMPTY;
      end
    end else if ((reject_code_r == ST_ACCEPTED) && (pos > E_POS) &&
                 (pos >= payload_start) && !walk_done_r) begin
      if (in_block_header_r) begin
        unique case (byte_phase_r)
          2'd0: begin
            low_byte_hold_nxt = b;
            byte_phase_nxt    = 2'd1;
          end
          2'd1: begin
            current_identifier_nxt = {b, low_byte_hold_r};
            byte_phase_nxt         = 2'd2;
          end
          2'd2: begin
            low_byte_hold_nxt = b;
            byte_phase_nxt    = 2'd3;
          end
          default: begin
            current_azimuth_nxt = {b, low_byte_hold_r};
            byte_phase_nxt      = 2'd0;
            in_block_header_nxt = 1'b0;
          end
        endcase
      end else if (byte_phase_r == 2'd0) begin
        low_byte_hold_nxt = b;
        byte_phase_nxt    = 2'd1;
      end else if (byte_phase_r == 2'd1) begin
        current_distance_nxt = {b, low_byte_hold_r};
        byte_phase_nxt       = 2'd2;
      end else begin
        byte_phase_nxt = 2'd0;
        emit_laser     = 1'b1;
        if (laser_counter_r + LC_W'(1) >= LC_W'(LASERS_PER_BLOCK)) begin
          laser_counter_nxt   = '0;
          in_block_header_nxt = 1'b1;
          block_counter_nxt   = block_counter_r + BC_W'(1);
          if (block_counter_r + BC_W'(1) >= BC_W'(FIRING_BLOCKS)) begin
            walk_done_nxt = 1'b1;
          end
        end else begin
          laser_counter_nxt = laser_counter_r + LC_W'(1);
        end
      end
    end

    if (in_tlast) begin
      byte_position_nxt      = '0;
      ip_header_bytes_nxt    = '0;
      ip_total_length_nxt    = '0;
      reject_code_nxt        = ST_ACCEPTED;
      port_high_byte_nxt     = '0;
      low_byte_hold_nxt      = '0;
      current_identifier_nxt = '0;
      current_azimuth_nxt    = '0;
      current_distance_nxt   = '0;
      block_counter_nxt      = '0;
      laser_counter_nxt      = '0;
      byte_phase_nxt         = '0;
      in_block_header_nxt    = 1'b1;
      walk_done_nxt          = 1'b0;
    end else if (byte_position_r < POS_MAX) begin
      byte_position_nxt = byte_position_r + POS_W'(1);
    end
  end

  always_comb begin
    status_code = reject_code_r;
    if ((reject_code_r == ST_ACCEPTED) &&
        ((pos + CALC_W'(1) < payload_start) || (pos <= E_POS))) begin
      status_code = ST_EMPTY;
    end

    laser_rec.record_kind      = KIND_LASER;
    laser_rec.block_index      = 4'(block_counter_r);
    laser_rec.block_identifier = current_identifier_r;
    laser_rec.azimuth          = current_azimuth_r;
    laser_rec.laser_index      = 5'(laser_counter_r);
    laser_rec.distance         = current_distance_r;
    laser_rec.intensity        = b;
    laser_rec.frame_status     = ST_ACCEPTED;
    laser_rec.last             = 1'b0;

    status_rec.record_kind      = KIND_STATUS;
    status_rec.block_index      = '0;
    status_rec.block_identifier = '0;
    status_rec.azimuth          = '0;
    status_rec.laser_index      = '0;
    status_rec.distance         = '0;
    status_rec.intensity        = '0;
    status_rec.frame_status     = status_code;
    status_rec.last             = 1'b1;
  end

  // output queue
  logic [1:0] push_cnt;
  logic [2:0] count_nxt;

  assign out_tvalid = (count_r != 3'd0);
  assign out_fire   = out_tvalid && out_tready;
  assign push_cnt   = in_fire ? (2'(emit_laser) + 2'(in_tlast)) : 2'd0;
  assign count_nxt  = count_r + 3'(push_cnt) - 3'(out_fire);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (emit_laser) begin
        queue_r[wr_ptr_r] <= laser_rec;
        if (in_tlast) begin
          queue_r[wr_ptr_r + 2'd1] <= status_rec;
        end
      end else if (in_tlast) begin
        queue_r[wr_ptr_r] <= status_rec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + push_cnt;
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lidar_port_r <= LIDAR_PORT_RESET;
    end else if (cfg_wr_en) begin
      lidar_port_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_position_r      <= '0;
      ip_header_bytes_r    <= '0;
      ip_total_length_r    <= '0;
      reject_code_r        <= ST_ACCEPTED;
      port_high_byte_r     <= '0;
      low_byte_hold_r      <= '0;
      current_identifier_r <= '0;
      current_azimuth_r    <= '0;
      current_distance_r   <= '0;
      block_counter_r      <= '0;
      laser_counter_r      <= '0;
      byte_phase_r         <= '0;
      in_block_header_r    <= 1'b1;
      walk_done_r          <= 1'b0;
    end else if (in_fire) begin
      byte_position_r      <= byte_position_nxt;
      ip_header_bytes_r    <= ip_header_bytes_nxt;
      ip_total_length_r    <= ip_total_length_nxt;
      reject_code_r        <= reject_code_nxt;
      port_high_byte_r     <= port_high_byte_nxt;
      low_byte_hold_r      <= low_byte_hold_nxt;
      current_identifier_r <= current_identifier_nxt;
      current_azimuth_r    <= current_azimuth_nxt;
      current_distance_r   <= current_distance_nxt;
      block_counter_r      <= block_counter_nxt;
      laser_counter_r      <= laser_counter_nxt;
      byte_phase_r         <= byte_phase_nxt;
      in_block_header_r    <= in_block_header_nxt;
      walk_done_r          <= walk_done_nxt;
    end
  end

  record_t head;

  assign head      = queue_r[rd_ptr_r];
  assign out_tuser = head.record_kind;
  assign out_tlast = head.last;
  assign out_tdata = {4'b0000, head.frame_status, head.intensity, head.distance,
                      head.laser_index, head.azimuth, head.block_identifier,
                      head.block_index};

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lidar UDP packet parser.
// Frames are fed byte by byte under bursty input and a stalling receiver.
// Every record is checked against an in-bench parser model. A table of
// directed frames comes first: header truncation, each reject reason and
// its priority, and records that close on the final byte. Random
// well-formed frames follow, with broken and noise frames mixed in, under
// several port settings.
// ----------------------------------------------------------------------------
module tb_top;
  import ludp_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_LIMIT   = 10;
  localparam int PHASE_BYTES    = 80;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_NOISE} fill_t;
  typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_LONG_STALL} rx_mode_t;

  typedef struct {
    logic [3:0]    ihl_nib;
    logic [15:0]   tot_len;
    logic [7:0]    proto;
    logic [15:0]   dport;
    int            n_bytes;
    fill_t         fill;
    bit            typed;
    frame_status_t status;
  } frame_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [15:0]           cfg_wr_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  lidar_udp_packet_parser u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // parser model state
  logic [15:0]   rx_port = LIDAR_PORT_RESET;
  logic [POS_W-1:0] fr_pos = '0;
  logic [5:0]    fr_ihl_bytes = '0;
  logic [15:0]   fr_tot_len = '0;
  frame_status_t fr_reject = ST_ACCEPTED;
  logic [7:0]    fr_port_hi = '0;
  logic [7:0]    fr_lo = '0;
  logic [15:0]   fr_id = '0;
  logic [15:0]   fr_az = '0;
  logic [15:0]   fr_dist = '0;
  int            fr_blk = 0;
  int            fr_lsr = 0;
  logic [1:0]    fr_phase = '0;
  bit            fr_in_hdr = 1'b1;
  bit            fr_walk_done = 1'b0;

  record_t       pending_records[$];
  logic [7:0]    frame_bytes[$];
  bit            force_status = 1'b0;
  frame_status_t forced_status = ST_ACCEPTED;

  int burst_left = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  int laser_seen = 0;
  int status_seen = 0;
  int accepted_seen = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int rx_left = 0;
  int rx_tick = 0;
  rx_mode_t rx_mode = RX_OPEN;

  frame_row_t directed_rows[13] = '{
    '{4'h5, 16'd100,   8'd17, LIDAR_PORT_RESET, 1,   FILL_RANDOM, 1'b1, ST_EMPTY},
    '{4'h5, 16'd100,   8'd17, LIDAR_PORT_RESET, 15,  FILL_RANDOM, 1'b1, ST_EMPTY},
    '{4'h4, 16'd100,   8'd17, LIDAR_PORT_RESET, 40,  FILL_RANDOM, 1'b1, ST_SHORT_IHL},
    '{4'h0, 16'd100,   8'd6,  LIDAR_PORT_RESET, 40,  FILL_RANDOM, 1'b1, ST_SHORT_IHL},
    '{4'h5, 16'd100,   8'd6,  LIDAR_PORT_RESET, 42,  FILL_RANDOM, 1'b1, ST_NOT_UDP},
    '{4'h5, 16'd100,   8'd17, 16'hFFFF,         42,  FILL_RANDOM, 1'b1, ST_BAD_PORT},
    '{4'h5, 16'd0,     8'd17, 16'h0000,         42,  FILL_RANDOM, 1'b1, ST_BAD_PORT},
    '{4'h5, 16'd28,    8'd17, LIDAR_PORT_RESET, 42,  FILL_RANDOM, 1'b1, ST_EMPTY},
    '{4'h5, 16'hFFFF,  8'd17, LIDAR_PORT_RESET, 41,  FILL_RANDOM, 1'b1, ST_EMPTY},
    '{4'h5, 16'd29,    8'd17, LIDAR_PORT_RESET, 42,  FILL_RANDOM, 1'b1, ST_ACCEPTED},
    '{4'h5, 16'd200,   8'd17, LIDAR_PORT_RESET, 52,  FILL_RANDOM, 1'b0, ST_ACCEPTED},
    '{4'hF, 16'hFFFF,  8'd17, LIDAR_PORT_RESET, 185, FILL_ONES,   1'b0, ST_ACCEPTED},
    '{4'h5, 16'd1000,  8'd17, LIDAR_PORT_RESET, 49,  FILL_ZERO,   1'b0, ST_ACCEPTED}
  };

  task automatic clear_frame_state();
    fr_pos       = '0;
    fr_ihl_bytes = '0;
    fr_tot_len   = '0;
    fr_reject    = ST_ACCEPTED;
    fr_port_hi   = '0;
    fr_lo        = '0;
    fr_id        = '0;
    fr_az        = '0;
    fr_dist      = '0;
    fr_blk       = 0;
    fr_lsr       = 0;
    fr_phase     = '0;
    fr_in_hdr    = 1'b1;
    fr_walk_done = 1'b0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic l);
    int            pos;
    int            ihl;
    int            pstart;
    record_t       r;
    frame_status_t st;
    pos    = int'(fr_pos);
    ihl    = int'(fr_ihl_bytes);
    pstart = ETH_HEADER_BYTES + ihl + UDP_HEADER_BYTES;
    if (pos == ETH_HEADER_BYTES) begin
      fr_ihl_bytes = {b[3:0], 2'b00};
      if (fr_ihl_bytes < MIN_IP_HEADER && fr_reject == ST_ACCEPTED) fr_reject = ST_SHORT_IHL;
    end else if (pos == ETH_HEADER_BYTES + 2) begin
      fr_tot_len = {b, 8'h00};
    end else if (pos == ETH_HEADER_BYTES + 3) begin
      fr_tot_len[7:0] = b;
    end else if (pos == ETH_HEADER_BYTES + 9) begin
      if (fr_reject == ST_ACCEPTED && b != 8'(PROTO_UDP)) fr_reject = ST_NOT_UDP;
    end else if (fr_reject == ST_ACCEPTED && pos == ETH_HEADER_BYTES + ihl + 2) begin
      fr_port_hi = b;
    end else if (fr_reject == ST_ACCEPTED && pos == ETH_HEADER_BYTES + ihl + 3) begin
      if ({fr_port_hi, b} != rx_port) fr_reject = ST_BAD_PORT;
      else if (int'(fr_tot_len) <= ihl + UDP_HEADER_BYTES) fr_reject = ST_EMPTY;
    end else if (fr_reject == ST_ACCEPTED && pos > ETH_HEADER_BYTES && pos >= pstart &&
                 !fr_walk_done) begin
      if (fr_in_hdr) begin
        case (fr_phase)
          2'd0, 2'd2: fr_lo = b;
          2'd1: fr_id = {b, fr_lo};
          default: begin
            fr_az = {b, fr_lo};
            fr_in_hdr = 1'b0;
          end
        endcase
        fr_phase = fr_phase + 2'd1;
      end else if (fr_phase == 2'd0) begin
        fr_lo = b;
        fr_phase = 2'd1;
      end else if (fr_phase == 2'd1) begin
        fr_dist = {b, fr_lo};
        fr_phase = 2'd2;
      end else begin
        fr_phase = 2'd0;
        r = '0;
        r.record_kind      = KIND_LASER;
        r.block_index      = 4'(fr_blk);
        r.block_identifier = fr_id;
        r.azimuth          = fr_az;
        r.laser_index      = 5'(fr_lsr);
        r.distance         = fr_dist;
        r.intensity        = b;
        r.frame_status     = ST_ACCEPTED;
        r.last             = 1'b0;
        pending_records.push_back(r);
        fr_lsr++;
        if (fr_lsr >= LASERS_PER_BLOCK) begin
          fr_lsr = 0;
          fr_in_hdr = 1'b1;
          fr_blk++;
          if (fr_blk >= FIRING_BLOCKS) fr_walk_done = 1'b1;
        end
      end
    end
    if (l) begin
      st = fr_reject;
      if (st == ST_ACCEPTED && (pos + 1 < pstart || pos <= ETH_HEADER_BYTES)) st = ST_EMPTY;
      if (force_status) st = forced_status;
      r = '0;
      r.record_kind  = KIND_STATUS;
      r.frame_status = st;
      r.last         = 1'b1;
      pending_records.push_back(r);
      clear_frame_state();
    end else if (fr_pos != '1) begin
      fr_pos = fr_pos + 1'b1;
    end
  endtask

  task automatic build_frame(input logic [3:0] ihl_nib, input logic [15:0] tot_len,
                             input logic [7:0] proto, input logic [15:0] dport,
                             input int n_bytes, input fill_t fill);
    int         hdr;
    int         k;
    logic [7:0] v;
    hdr = (ihl_nib < 4'd5) ? MIN_IP_HEADER : int'(ihl_nib) * 4;
    frame_bytes.delete();
    for (k = 0; k < n_bytes; k++) begin
      case (fill)
        FILL_ZERO: v = 8'h00;
        FILL_ONES: v = 8'hFF;
        default:   v = 8'($urandom);
      endcase
      if (fill != FILL_NOISE) begin
        if (k == ETH_HEADER_BYTES) v = {4'h4, ihl_nib};
        else if (k == ETH_HEADER_BYTES + 2) v = tot_len[15:8];
        else if (k == ETH_HEADER_BYTES + 3) v = tot_len[7:0];
        else if (k == ETH_HEADER_BYTES + 9) v = proto;
        else if (k == ETH_HEADER_BYTES + hdr + 2) v = dport[15:8];
        else if (k == ETH_HEADER_BYTES + hdr + 3) v = dport[7:0];
      end
      frame_bytes.push_back(v);
    end
  endtask

  task automatic drive_byte(input logic [7:0] b, input logic l);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) :
                                                 $urandom_range(1, 40);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    parse_byte(b, l);
    bytes_sent++;
  endtask

  task automatic send_frame();
    int k;
    for (k = 0; k < frame_bytes.size(); k++) drive_byte(frame_bytes[k], k == frame_bytes.size() - 1);
    frames_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_port(input logic [15:0] p);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= p;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    rx_port = p;
  endtask

  task automatic random_frame();
    int          sel;
    int          hdr;
    int          n;
    logic [3:0]  ihl_nib;
    logic [15:0] tot_len;
    logic [7:0]  proto;
    logic [15:0] dport;
    fill_t       fill;
    sel     = $urandom_range(0, 99);
    ihl_nib = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
    hdr     = int'(ihl_nib) * 4;
    tot_len = 16'($urandom_range(hdr + UDP_HEADER_BYTES + 1, 65535));
    proto   = 8'(PROTO_UDP);
    dport   = rx_port;
    fill    = FILL_RANDOM;
    n       = ETH_HEADER_BYTES + hdr + UDP_HEADER_BYTES + $urandom_range(0, 40);
    if (sel < 20) begin
      n = ETH_HEADER_BYTES + hdr + UDP_HEADER_BYTES + $urandom_range(40, 200);
    end else if (sel < 30) begin
      n = $urandom_range(1, ETH_HEADER_BYTES + hdr + UDP_HEADER_BYTES);
    end else if (sel < 36) begin
      proto = 8'($urandom);
      if (proto == 8'(PROTO_UDP)) proto = 8'd6;
    end else if (sel < 42) begin
      dport = rx_port ^ 16'($urandom_range(1, 65535));
    end else if (sel < 47) begin
      ihl_nib = 4'($urandom_range(0, 4));
    end else if (sel < 52) begin
      tot_len = 16'($urandom_range(0, hdr + UDP_HEADER_BYTES));
    end else if (sel < 60) begin
      fill = FILL_NOISE;
      n = $urandom_range(1, 60);
    end
    build_frame(ihl_nib, tot_len, proto, dport, n, fill);
    send_frame();
  endtask

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 150);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN:    out_tready <= 1'b1;
      RX_RANDOM:  out_tready <= ($urandom_range(0, 3) != 0);
      RX_PATTERN: out_tready <= ((rx_tick % 5) < 2);
      default:    out_tready <= ((rx_tick % 16) >= 12);
    endcase
  end

  always @(posedge clk) begin : check_records
    record_t got;
    record_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.record_kind      = record_kind_t'(out_tuser);
      got.block_index      = out_tdata[3:0];
      got.block_identifier = out_tdata[19:4];
      got.azimuth          = out_tdata[35:20];
      got.laser_index      = out_tdata[40:36];
      got.distance         = out_tdata[56:41];
      got.intensity        = out_tdata[64:57];
      got.frame_status     = frame_status_t'(out_tdata[67:65]);
      got.last             = out_tlast;
      if (got.record_kind == KIND_STATUS) begin
        status_seen++;
        if (got.frame_status == ST_ACCEPTED) accepted_seen++;
      end else begin
        laser_seen++;
      end
      if (pending_records.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected record kind=%0d status=%0d", $realtime,
                   got.record_kind, got.frame_status);
      end else begin
        want = pending_records.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: record mismatch", $realtime);
            $display("  exp kind=%0d blk=%0d id=%h az=%h lsr=%0d dist=%h int=%h st=%0d last=%0d",
                     want.record_kind, want.block_index, want.block_identifier, want.azimuth,
                     want.laser_index, want.distance, want.intensity, want.frame_status,
                     want.last);
            $display("  got kind=%0d blk=%0d id=%h az=%h lsr=%0d dist=%h int=%h st=%0d last=%0d",
                     got.record_kind, got.block_index, got.block_identifier, got.azimuth,
                     got.laser_index, got.distance, got.intensity, got.frame_status,
                     got.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles, %0d records outstanding",
                 quiet_cycles, pending_records.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : main
    logic [15:0] phase_ports[4];
    int          p;
    int          start;
    phase_ports = '{16'h0000, 16'hFFFF, 16'($urandom_range(1, 65534)), LIDAR_PORT_RESET};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    clear_frame_state();

    foreach (directed_rows[i]) begin
      force_status  = directed_rows[i].typed;
      forced_status = directed_rows[i].status;
      build_frame(directed_rows[i].ihl_nib, directed_rows[i].tot_len, directed_rows[i].proto,
                  directed_rows[i].dport, directed_rows[i].n_bytes, directed_rows[i].fill);
      send_frame();
    end
    force_status = 1'b0;

    for (p = 0; p < 4; p++) begin
      write_port(phase_ports[p]);
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) random_frame();
    end

    in_tvalid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("%0d frames, %0d bytes sent; %0d laser and %0d status records checked",
             frames_sent, bytes_sent, laser_seen, status_seen);
    $display("%0d frames accepted, %0d rejected, %0d mismatches",
             accepted_seen, status_seen - accepted_seen, mismatches);
    if (mismatches == 0 && pending_records.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
